### rtl/code14_range_mapper_defines.svh
// Assertion macros for the code14 range mapper.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef CODE14_RANGE_MAPPER_DEFINES_SVH
`define CODE14_RANGE_MAPPER_DEFINES_SVH

// same-cycle implication
`define CRM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crm assertion failed");

// next-cycle implication
`define CRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crm assertion failed");

`endif

### rtl/crm_pkg.sv
// Shared constants for the code14 range mapper.
// No dependencies.
package crm_pkg;

    localparam int CODE_BITS_DEF  = 14;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic KIND_TO_VALUE = 1'b0;
    localparam logic KIND_TO_CODE  = 1'b1;

    localparam logic [1:0] PK_LINEAR = 2'd0;
    localparam logic [1:0] PK_LABEL  = 2'd1;
    localparam logic [1:0] PK_BOOL   = 2'd2;

endpackage

### rtl/crm_in_if.sv
// Input item channel of the code14 range mapper.
// Depends on crm_pkg.
interface crm_in_if #(
    parameter int CODE_BITS  = crm_pkg::CODE_BITS_DEF,
    parameter int VALUE_BITS = crm_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [1:0]                   param_kind;
    logic signed [VALUE_BITS-1:0] range_low_end;
    logic signed [VALUE_BITS-1:0] range_high_end;
    logic [CODE_BITS-1:0]         code_in;
    logic signed [VALUE_BITS-1:0] value_in;

    modport source (
        output valid, kind, param_kind, range_low_end, range_high_end, code_in, value_in,
        input  ready
    );
    modport sink (
        input  valid, kind, param_kind, range_low_end, range_high_end, code_in, value_in,
        output ready
    );
endinterface

### rtl/crm_out_if.sv
// Result item channel of the code14 range mapper.
// Depends on crm_pkg.
interface crm_out_if #(
    parameter int CODE_BITS  = crm_pkg::CODE_BITS_DEF,
    parameter int VALUE_BITS = crm_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] range_value;
    logic [CODE_BITS-1:0]         code_value;

    modport source (output valid, range_value, code_value, input ready);
    modport sink   (input valid, range_value, code_value, output ready);
endinterface

### rtl/crm_div_cell.sv
// One restoring-division cell: retires one numerator bit per item per cycle while enabled.
// No dependencies; chained by the top level.
module crm_div_cell #(
    parameter int NW     = 46,
    parameter int DW     = 32,
    parameter int QW     = 33,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_rem,
    input  logic [QW-1:0]     i_quo,
    input  logic [DW-1:0]     i_div,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NW-1:0]     o_num,
    output logic [DW-1:0]     o_rem,
    output logic [QW-1:0]     o_quo,
    output logic [DW-1:0]     o_div,
    output logic [SIDE_W-1:0] o_side
);
    logic              r_valid;
    logic [NW-1:0]     r_num;
    logic [DW-1:0]     r_rem;
    logic [QW-1:0]     r_quo;
    logic [DW-1:0]     r_div;
    logic [SIDE_W-1:0] r_side;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic [NW-1:0] n_num;

    always_comb begin
        trial = {i_rem, i_num[NW-1]};
        diff  = trial - {1'b0, i_div};
        ge    = (trial >= {1'b0, i_div});
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_quo = {i_quo[QW-2:0], ge};
        n_num = {i_num[NW-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_side  = r_side;
endmodule

### rtl/crm_prep.sv
// Front end: range decode, special cases, then the numerator product plus the label bias.
// Depends on crm_pkg; feeds the division chain.
module crm_prep #(
    parameter int CODE_BITS  = crm_pkg::CODE_BITS_DEF,
    parameter int VALUE_BITS = crm_pkg::VALUE_BITS_DEF,
    parameter int NW         = CODE_BITS + VALUE_BITS,
    parameter int DW         = VALUE_BITS,
    parameter int SIDE_W     = 3 + 3 * VALUE_BITS + CODE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic                         i_kind,
    input  logic [1:0]                   i_param_kind,
    input  logic signed [VALUE_BITS-1:0] i_lo,
    input  logic signed [VALUE_BITS-1:0] i_hi,
    input  logic [CODE_BITS-1:0]         i_code,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_valid,
    output logic [NW-1:0]                o_num,
    output logic [DW-1:0]                o_div,
    output logic [SIDE_W-1:0]            o_side
);
    localparam int CB = CODE_BITS;
    localparam int VB = VALUE_BITS;
    localparam logic [CB-1:0] FULL = {CB{1'b1}};
    localparam logic [CB-1:0] HALF = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] BIAS = {1'b0, {(CB-1){1'b1}}};

    logic          dir;
    logic [VB:0]   hi_m_lo;
    logic [VB:0]   lo_m_hi;
    logic [VB:0]   v_m_lo;
    logic [VB:0]   lo_m_v;
    logic [VB-1:0] span;
    logic          n_special;
    logic [VB-1:0] n_spec_val;
    logic [CB-1:0] n_spec_code;
    logic [CB-1:0] n_a;
    logic [VB-1:0] n_b;
    logic          n_bias;
    logic [DW-1:0] n_div;

    logic              r_valid1;
    logic [CB-1:0]     r_a;
    logic [VB-1:0]     r_b;
    logic              r_bias;
    logic [DW-1:0]     r_div1;
    logic [SIDE_W-1:0] r_side1;

    logic              r_valid2;
    logic [NW-1:0]     r_num;
    logic [DW-1:0]     r_div2;
    logic [SIDE_W-1:0] r_side2;

    logic [NW-1:0] prod;

    always_comb begin
        dir     = (i_hi >= i_lo);
        hi_m_lo = {i_hi[VB-1], i_hi} - {i_lo[VB-1], i_lo};
        lo_m_hi = {i_lo[VB-1], i_lo} - {i_hi[VB-1], i_hi};
        v_m_lo  = {i_value[VB-1], i_value} - {i_lo[VB-1], i_lo};
        lo_m_v  = {i_lo[VB-1], i_lo} - {i_value[VB-1], i_value};
        span    = dir ? hi_m_lo[VB-1:0] : lo_m_hi[VB-1:0];

        n_special   = 1'b0;
        n_spec_val  = i_lo;
        n_spec_code = '0;
        n_a         = FULL;
        n_b         = '0;
        n_bias      = 1'b0;
        n_div       = DW'(span);

        if (i_kind == crm_pkg::KIND_TO_VALUE) begin
            n_a    = i_code;
            n_b    = span;
            n_bias = (i_param_kind == crm_pkg::PK_LABEL);
            n_div  = DW'(FULL);
            if (i_param_kind == crm_pkg::PK_BOOL) begin
                n_special  = 1'b1;
                n_spec_val = (i_code < HALF) ? i_lo : i_hi;
            end else if (i_code == '0) begin
                n_special  = 1'b1;
                n_spec_val = i_lo;
            end else if (i_code == FULL) begin
                n_special  = 1'b1;
                n_spec_val = i_hi;
            end
        end else begin
            if (i_param_kind == crm_pkg::PK_BOOL) begin
                n_special   = 1'b1;
                n_spec_code = (i_value == i_lo) ? '0 : FULL;
            end else if (dir) begin
                n_b = v_m_lo[VB-1:0];
                if (i_value <= i_lo) begin
                    n_special   = 1'b1;
                    n_spec_code = '0;
                end else if (i_value >= i_hi) begin
                    n_special   = 1'b1;
                    n_spec_code = FULL;
                end
            end else begin
                n_b = lo_m_v[VB-1:0];
                if (i_value >= i_lo) begin
                    n_special   = 1'b1;
                    n_spec_code = '0;
                end else if (i_value <= i_hi) begin
                    n_special   = 1'b1;
                    n_spec_code = FULL;
                end
            end
        end
    end

    assign prod = r_a * r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_bias  <= n_bias;
            r_div1  <= n_div;
            r_side1 <= {i_kind, n_special, dir, n_spec_val, n_spec_code, i_lo, span};
            r_num   <= prod + (r_bias ? NW'(BIAS) : NW'(0));
            r_div2  <= r_div1;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_valid2;
    assign o_num   = r_num;
    assign o_div   = r_div2;
    assign o_side  = r_side2;
endmodule

### rtl/code14_range_mapper.sv
// Code14 range mapper: converts a 14-bit controller code to a value in a signed range, or
// back. Fully pipelined: one item per cycle while the output is not held. Each item passes
// two front-end stages (decode, product), then the chain of division cells, one per numerator
// bit, then the output register. A result held at the output stalls the whole pipeline.
// Depends on crm_pkg, crm_in_if, crm_out_if, crm_prep, crm_div_cell and the defines header.
`include "code14_range_mapper_defines.svh"
module code14_range_mapper #(
    parameter int CODE_BITS  = crm_pkg::CODE_BITS_DEF,
    parameter int VALUE_BITS = crm_pkg::VALUE_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    crm_in_if.sink   i_item,
    crm_out_if.source o_item
);
    localparam int CB     = CODE_BITS;
    localparam int VB     = VALUE_BITS;
    localparam int NW     = CB + VB;
    localparam int DW     = (CB > VB) ? CB : VB;
    localparam int QW     = DW + 1;
    localparam int SIDE_W = 3 + 3 * VB + CB;
    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    logic en;

    logic              c_valid [0:NW];
    logic [NW-1:0]     c_num   [0:NW];
    logic [DW-1:0]     c_rem   [0:NW];
    logic [QW-1:0]     c_quo   [0:NW];
    logic [DW-1:0]     c_div   [0:NW];
    logic [SIDE_W-1:0] c_side  [0:NW];

    logic              r_out_valid;
    logic              r_out_kind;
    logic [VB-1:0]     r_range_value;
    logic [CB-1:0]     r_code_value;

    logic          p_kind;
    logic          p_special;
    logic          p_dir;
    logic [VB-1:0] p_spec_val;
    logic [CB-1:0] p_spec_code;
    logic [VB-1:0] p_lo;
    logic [VB-1:0] p_span;
    logic [QW-1:0] q;
    logic [VB-1:0] step;
    logic [VB-1:0] fwd;
    logic [CB-1:0] bwd;
    logic [VB-1:0] n_range_value;
    logic [CB-1:0] n_code_value;

    assign en           = !r_out_valid || o_item.ready;
    assign i_item.ready = en;

    crm_prep #(
        .CODE_BITS (CODE_BITS),
        .VALUE_BITS(VALUE_BITS),
        .NW        (NW),
        .DW        (DW),
        .SIDE_W    (SIDE_W)
    ) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_item.valid),
        .i_kind      (i_item.kind),
        .i_param_kind(i_item.param_kind),
        .i_lo        (i_item.range_low_end),
        .i_hi        (i_item.range_high_end),
        .i_code      (i_item.code_in),
        .i_value     (i_item.value_in),
        .o_valid     (c_valid[0]),
        .o_num       (c_num[0]),
        .o_div       (c_div[0]),
        .o_side      (c_side[0])
    );

    assign c_rem[0] = '0;
    assign c_quo[0] = '0;

    for (genvar g = 0; g < NW; g++) begin : g_cell
        crm_div_cell #(
            .NW    (NW),
            .DW    (DW),
            .QW    (QW),
            .SIDE_W(SIDE_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(c_valid[g]),
            .i_num  (c_num[g]),
            .i_rem  (c_rem[g]),
            .i_quo  (c_quo[g]),
            .i_div  (c_div[g]),
            .i_side (c_side[g]),
            .o_valid(c_valid[g+1]),
            .o_num  (c_num[g+1]),
            .o_rem  (c_rem[g+1]),
            .o_quo  (c_quo[g+1]),
            .o_div  (c_div[g+1]),
            .o_side (c_side[g+1])
        );
    end

    always_comb begin
        {p_kind, p_special, p_dir, p_spec_val, p_spec_code, p_lo, p_span} = c_side[NW];
        q    = c_quo[NW];
        step = (q > QW'(p_span)) ? p_span : q[VB-1:0];
        fwd  = p_special ? p_spec_val : (p_dir ? (p_lo + step) : (p_lo - step));
        bwd  = p_special ? p_spec_code : q[CB-1:0];
        if (p_kind == crm_pkg::KIND_TO_VALUE) begin
            n_range_value = fwd;
            n_code_value  = '0;
        end else begin
            n_range_value = '0;
            n_code_value  = bwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_valid[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_kind    <= p_kind;
            r_range_value <= n_range_value;
            r_code_value  <= n_code_value;
        end
    end

    assign o_item.valid       = r_out_valid;
    assign o_item.range_value = r_range_value;
    assign o_item.code_value  = r_code_value;

    `CRM_ASSERT_IMPL(a_fwd_quo_range,
        c_valid[NW] && (p_kind == crm_pkg::KIND_TO_VALUE) && !p_special,
        q <= (QW'(p_span) + QW'(1)))
    `CRM_ASSERT_IMPL(a_bwd_quo_range,
        c_valid[NW] && (p_kind == crm_pkg::KIND_TO_CODE) && !p_special,
        q < QW'(FULL))
    `CRM_ASSERT_IMPL(a_fwd_code_zero,
        r_out_valid && (r_out_kind == crm_pkg::KIND_TO_VALUE),
        r_code_value == '0)
    `CRM_ASSERT_NEXT(a_hold_stall,
        r_out_valid && !o_item.ready,
        $stable(c_quo[NW]) && $stable(c_valid[NW]))
endmodule

### dv/code14_range_mapper_tb.sv
// Self-checking testbench for the code14 range mapper: predicts each conversion from the
// input item and compares it with the result item in order, under random idling on both sides.
// Depends on crm_pkg, crm_in_if, crm_out_if and the code14_range_mapper RTL.
`timescale 1ns / 100ps
module code14_range_mapper_tb;

    localparam int CB = crm_pkg::CODE_BITS_DEF;
    localparam int VB = crm_pkg::VALUE_BITS_DEF;
    localparam logic [63:0] FULL = (64'd1 << CB) - 64'd1;
    localparam logic [63:0] HALF = 64'd1 << (CB - 1);
    localparam logic [CB-1:0] CODE_FULL = {CB{1'b1}};
    localparam logic [CB-1:0] CODE_HALF = {1'b1, {(CB-1){1'b0}}};
    localparam int LATENCY = 3 + CB + VB;

    typedef struct packed {
        logic signed [VB-1:0] range_value;
        logic [CB-1:0]        code_value;
    } t_conv;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    crm_in_if  in_ch ();
    crm_out_if out_ch ();

    code14_range_mapper dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(in_ch), .o_item(out_ch));

    always #5 i_clk = ~i_clk;

    t_conv expected_q[$];
    int    mismatches = 0;
    int    results_seen = 0;
    int    sink_wait = 0;
    bit    hold_active = 1'b0;

    function automatic logic signed [63:0] to_value(logic [1:0] pk,
                                                    logic signed [63:0] lo,
                                                    logic signed [63:0] hi, logic [63:0] code);
        logic signed [63:0] rmin, rmax, res;
        logic [63:0] span, step;
        rmin = (lo < hi) ? lo : hi;
        rmax = (lo < hi) ? hi : lo;
        span = rmax - rmin;
        if (code > FULL) code = FULL;
        if (pk == crm_pkg::PK_BOOL) return (code < HALF) ? lo : hi;
        if (code == 64'd0) return lo;
        if (code == FULL) return hi;
        if (pk == crm_pkg::PK_LABEL) step = (code * span + (HALF - 64'd1)) / FULL;
        else step = (code * span) / FULL;
        if (step > span) step = span;
        res = (hi >= lo) ? lo + $signed(step) : lo - $signed(step);
        if (res < rmin) res = rmin;
        if (res > rmax) res = rmax;
        return res;
    endfunction

    function automatic logic [63:0] to_code(logic [1:0] pk, logic signed [63:0] lo,
                                            logic signed [63:0] hi, logic signed [63:0] v);
        logic [63:0] d, s;
        if (pk == crm_pkg::PK_BOOL) return (v == lo) ? 64'd0 : FULL;
        if (hi >= lo) begin
            if (v <= lo) return 64'd0;
            if (v >= hi) return FULL;
            d = v - lo;
            s = hi - lo;
        end else begin
            if (v >= lo) return 64'd0;
            if (v <= hi) return FULL;
            d = lo - v;
            s = lo - hi;
        end
        if (s == 64'd0) return 64'd0;
        d = (d * FULL) / s;
        return (d > FULL) ? FULL : d;
    endfunction

    function automatic t_conv predict_conversion(logic kind, logic [1:0] pk,
                                                 logic signed [VB-1:0] lo,
                                                 logic signed [VB-1:0] hi,
                                                 logic [CB-1:0] code, logic signed [VB-1:0] v);
        t_conv r;
        logic signed [63:0] rv;
        logic [63:0] cv;
        r = '0;
        if (kind == crm_pkg::KIND_TO_VALUE) begin
            rv = to_value(pk, 64'(lo), 64'(hi), {{(64-CB){1'b0}}, code});
            r.range_value = rv[VB-1:0];
        end else begin
            cv = to_code(pk, 64'(lo), 64'(hi), 64'(v));
            r.code_value = cv[CB-1:0];
        end
        return r;
    endfunction

    task automatic send_item(logic kind, logic [1:0] pk, logic signed [VB-1:0] lo,
                             logic signed [VB-1:0] hi, logic [CB-1:0] code,
                             logic signed [VB-1:0] v);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.kind           <= kind;
        in_ch.param_kind     <= pk;
        in_ch.range_low_end  <= lo;
        in_ch.range_high_end <= hi;
        in_ch.code_in        <= code;
        in_ch.value_in       <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_q.push_back(predict_conversion(kind, pk, lo, hi, code, v));
    endtask

    function automatic logic signed [VB-1:0] rand_value();
        case ($urandom_range(0, 4))
            0: return $signed(32'h8000_0000 + $urandom_range(0, 3));
            1: return $signed(32'h7fff_fffc + $urandom_range(0, 3));
            2: return $signed($urandom_range(0, 400)) - 200;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic [CB-1:0] rand_code();
        case ($urandom_range(0, 3))
            0: return CB'($urandom_range(0, 2));
            1: return CB'(FULL - $urandom_range(0, 2));
            2: return CB'(HALF - 1 + $urandom_range(0, 2));
            default: return CB'($urandom);
        endcase
    endfunction

    // sink side: per-item wait, held low while a long hold-off runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_wait    <= 0;
        end else begin
            t_conv e;
            int    w;
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item %h", out_ch.range_value);
                end else begin
                    e = expected_q.pop_front();
                    if (e.range_value !== out_ch.range_value ||
                        e.code_value !== out_ch.code_value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp value %0d code %0d, got value %0d code %0d",
                                     e.range_value, e.code_value,
                                     out_ch.range_value, out_ch.code_value);
                    end
                end
                results_seen++;
            end
            if (hold_active) begin
                out_ch.ready <= 1'b0;
            end else if (out_ch.valid && out_ch.ready) begin
                sink_wait    <= w;
                out_ch.ready <= (w == 0);
            end else if (sink_wait > 0) begin
                sink_wait    <= sink_wait - 1;
                out_ch.ready <= (sink_wait == 1);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic hold_ready(int cycles);
        hold_active = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_active = 1'b0;
    endtask

    task automatic test_directed();
        logic signed [VB-1:0] mn, mx;
        mn = $signed(32'h8000_0000);
        mx = $signed(32'h7fff_ffff);
        for (int pk = 0; pk < 4; pk++) begin
            send_item(crm_pkg::KIND_TO_VALUE, 2'(pk), mn, mx, '0, '0);
            send_item(crm_pkg::KIND_TO_VALUE, 2'(pk), mn, mx, CODE_FULL, '0);
            send_item(crm_pkg::KIND_TO_VALUE, 2'(pk), mx, mn, CODE_HALF, '0);
            send_item(crm_pkg::KIND_TO_VALUE, 2'(pk), VB'(5), VB'(5), CB'(1234), '0);
            send_item(crm_pkg::KIND_TO_CODE, 2'(pk), mn, mx, '0, '0);
            send_item(crm_pkg::KIND_TO_CODE, 2'(pk), mx, mn, '0, mn);
        end
        send_item(crm_pkg::KIND_TO_CODE, crm_pkg::PK_LINEAR, VB'(7), VB'(7), CODE_FULL, VB'(8));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            logic signed [VB-1:0] lo, hi, v;
            lo = rand_value();
            hi = rand_value();
            v  = $urandom_range(0, 3) == 0 ? lo : rand_value();
            send_item(1'($urandom), 2'($urandom), lo, hi, rand_code(), v);
        end
    endtask

    task automatic test_backpressure();
        fork
            hold_ready(200);
        join_none
        test_random(150);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.kind <= 1'b0;
        in_ch.param_kind <= '0;
        in_ch.range_low_end <= '0;
        in_ch.range_high_end <= '0;
        in_ch.code_in <= '0;
        in_ch.value_in <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1000);
        test_backpressure();
        test_random(850);
        drain();
        if (mismatches == 0 && expected_q.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/crm_pkg.sv
rtl/crm_in_if.sv
rtl/crm_out_if.sv
rtl/crm_div_cell.sv
rtl/crm_prep.sv
rtl/code14_range_mapper.sv
dv/code14_range_mapper_tb.sv
